FILE: hdl/oemp_pkg.sv
// Shared types and constants of the off-screen edge marker path block.
`default_nettype none
package oemp_pkg;

	localparam int MAX_POINTS_DEF = 8;
	localparam int COORD_W = 10;

	// result status codes
	localparam logic [1:0] ST_POINT    = 2'd0;
	localparam logic [1:0] ST_VISIBLE  = 2'd1;
	localparam logic [1:0] ST_BAD_CFG  = 2'd2;
	localparam logic [1:0] ST_BAD_PATH = 2'd3;

	// register indexes on the configuration port
	localparam logic [2:0] REG_SCREEN_W  = 3'd0;
	localparam logic [2:0] REG_SCREEN_H  = 3'd1;
	localparam logic [2:0] REG_HIDE_RAD  = 3'd2;
	localparam logic [2:0] REG_INSET     = 3'd3;
	localparam logic [2:0] REG_MARK_LEN  = 3'd4;

	// register reset values
	localparam logic [9:0]  RST_SCREEN_W = 10'd144;
	localparam logic [9:0]  RST_SCREEN_H = 10'd168;
	localparam logic [9:0]  RST_HIDE_RAD = 10'd0;
	localparam logic [8:0]  RST_INSET    = 9'd2;
	localparam logic [11:0] RST_MARK_LEN = 12'd40;

	typedef struct packed {
		logic                 valid;
		logic [COORD_W-1:0]   y;
		logic [COORD_W-1:0]   x;
	} pt_t;

	typedef struct packed {
		logic done;
		logic bad_inset;
	} walk_res_t;

	typedef struct packed {
		logic done;
		logic visible;
	} dist_res_t;

endpackage
`default_nettype wire

FILE: hdl/oemp_dist.sv
// Hide-radius test: squared distance against squared radius on one shared multiplier.
`default_nettype none
module oemp_dist (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [9:0]         dx,
	input  wire logic [9:0]         dy,
	input  wire logic [9:0]         rad,
	output oemp_pkg::dist_res_t     res
);
	import oemp_pkg::*;

	logic        busy_q;
	logic [1:0]  step_q;
	logic        done_q;
	logic        vis_q;
	logic [9:0]  dx_q;
	logic [9:0]  dy_q;
	logic [9:0]  rad_q;
	logic [19:0] prod_q;
	logic [20:0] acc_q;
	logic [9:0]  mul_op;

	// operand for the single squarer: dx, then dy, then radius
	always_comb begin
		unique case (step_q)
			2'd0:    mul_op = dx_q;
			2'd1:    mul_op = dy_q;
			default: mul_op = rad_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 2'd0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dx_q  <= dx;
			dy_q  <= dy;
			rad_q <= rad;
		end else if (busy_q) begin
			prod_q <= mul_op * mul_op;
			unique case (step_q)
				2'd0: acc_q <= acc_q;
				2'd1: acc_q <= {1'b0, prod_q};
				2'd2: acc_q <= acc_q + {1'b0, prod_q};
				default: vis_q <= (acc_q <= {1'b0, prod_q});
			endcase
		end
	end

	assign res.done    = done_q;
	assign res.visible = vis_q;

endmodule
`default_nettype wire

FILE: hdl/oemp_walk.sv
// Perimeter walker: inset rectangle setup, anchor offset, one corner step per cycle.
`default_nettype none
module oemp_walk (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [31:0] px,
	input  wire logic signed [31:0] py,
	input  wire logic [9:0]         scr_w,
	input  wire logic [9:0]         scr_h,
	input  wire logic [8:0]         inset,
	input  wire logic [11:0]        mark_len,
	output oemp_pkg::pt_t           pt,
	output oemp_pkg::walk_res_t     res
);
	import oemp_pkg::*;

	localparam logic [1:0] W_IDLE = 2'd0;
	localparam logic [1:0] W_PREP = 2'd1;
	localparam logic [1:0] W_ANCH = 2'd2;
	localparam logic [1:0] W_STEP = 2'd3;

	logic [1:0]  wst_q;
	logic [9:0]  l_q, r_q, b_q, h_q, v_q, cx_q, cy_q;
	logic [11:0] per_q, len_q, hv_q, hhv_q, n_q, rem_q;
	logic [1:0]  side_q;

	// setup terms
	logic signed [11:0] lin_s, r_s, b_s;
	logic               bad_c;
	logic [9:0]         h_c, v_c, cx_c, cy_c;
	logic [11:0]        per_c, len_c;
	logic [1:0]         side_c;
	logic signed [31:0] l32, r32, b32;

	always_comb begin
		lin_s  = $signed({3'b000, inset});
		r_s    = $signed({2'b00, scr_w}) - 12'sd1 - lin_s;
		b_s    = $signed({2'b00, scr_h}) - 12'sd1 - lin_s;
		bad_c  = (lin_s >= r_s) || (lin_s >= b_s);
		h_c    = 10'(r_s - lin_s);
		v_c    = 10'(b_s - lin_s);
		per_c  = {(11'(h_c) + 11'(v_c)), 1'b0};
		len_c  = (mark_len > per_c) ? per_c : mark_len;
		l32    = $signed({23'd0, inset});
		r32    = 32'(r_s);
		b32    = 32'(b_s);
		if (px < l32)      cx_c = {1'b0, inset};
		else if (px > r32) cx_c = r_s[9:0];
		else               cx_c = px[9:0];
		if (py < l32)      cy_c = {1'b0, inset};
		else if (py > b32) cy_c = b_s[9:0];
		else               cy_c = py[9:0];
		if (py < 32'sd0)                          side_c = 2'd0;
		else if (px >= $signed({22'd0, scr_w}))   side_c = 2'd1;
		else if (py >= $signed({22'd0, scr_h}))   side_c = 2'd2;
		else                                      side_c = 2'd3;
	end

	// anchor offset on the perimeter, clockwise from the top left corner
	logic [11:0]        hv_c, hhv_c, anchor_c;
	logic signed [12:0] cur_c, n0_s;

	always_comb begin
		hv_c  = 12'(h_q) + 12'(v_q);
		hhv_c = hv_c + 12'(h_q);
		unique case (side_q)
			2'd0: anchor_c = 12'(cx_q) - 12'(l_q);
			2'd1: anchor_c = 12'(h_q) + 12'(cy_q) - 12'(l_q);
			2'd2: anchor_c = hv_c + 12'(r_q) - 12'(cx_q);
			default: anchor_c = hhv_c + 12'(b_q) - 12'(cy_q);
		endcase
		cur_c = $signed({1'b0, anchor_c}) - $signed({2'b00, len_q[11:1]});
		if (cur_c < 13'sd0)
			n0_s = cur_c + $signed({1'b0, per_q});
		else if (cur_c >= $signed({1'b0, per_q}))
			n0_s = cur_c - $signed({1'b0, per_q});
		else
			n0_s = cur_c;
	end

	// point and distance to the next corner at offset n
	logic        seg0, seg1, seg2;
	logic [11:0] x_c, y_c, gap_c, step_c;
	logic [12:0] nsum_c;
	logic [11:0] nnx_c;

	always_comb begin
		seg0 = n_q < 12'(h_q);
		seg1 = n_q < hv_q;
		seg2 = n_q < hhv_q;
		priority if (seg0) begin
			x_c   = 12'(l_q) + n_q;
			y_c   = 12'(l_q);
			gap_c = 12'(h_q) - n_q;
		end else if (seg1) begin
			x_c   = 12'(r_q);
			y_c   = 12'(l_q) + n_q - 12'(h_q);
			gap_c = hv_q - n_q;
		end else if (seg2) begin
			x_c   = 12'(r_q) + hv_q - n_q;
			y_c   = 12'(b_q);
			gap_c = hhv_q - n_q;
		end else begin
			x_c   = 12'(l_q);
			y_c   = 12'(b_q) + hhv_q - n_q;
			gap_c = per_q - n_q;
		end
		step_c = (rem_q < gap_c) ? rem_q : gap_c;
		nsum_c = 13'(n_q) + 13'(step_c);
		nnx_c  = (nsum_c >= 13'(per_q)) ? 12'(nsum_c - 13'(per_q)) : nsum_c[11:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wst_q <= W_IDLE;
		end else begin
			unique case (wst_q)
				W_IDLE: if (start) wst_q <= W_PREP;
				W_PREP: wst_q <= bad_c ? W_IDLE : W_ANCH;
				W_ANCH: wst_q <= W_STEP;
				default: if (rem_q == 12'd0) wst_q <= W_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (wst_q)
			W_PREP: begin
				l_q    <= {1'b0, inset};
				r_q    <= r_s[9:0];
				b_q    <= b_s[9:0];
				h_q    <= h_c;
				v_q    <= v_c;
				per_q  <= per_c;
				len_q  <= len_c;
				cx_q   <= cx_c;
				cy_q   <= cy_c;
				side_q <= side_c;
			end
			W_ANCH: begin
				hv_q  <= hv_c;
				hhv_q <= hhv_c;
				n_q   <= n0_s[11:0];
				rem_q <= len_q;
			end
			W_STEP: begin
				n_q   <= nnx_c;
				rem_q <= rem_q - step_c;
			end
			default: begin
				n_q <= n_q;
			end
		endcase
	end

	assign pt.valid      = (wst_q == W_STEP);
	assign pt.x          = x_c[9:0];
	assign pt.y          = y_c[9:0];
	assign res.done      = ((wst_q == W_STEP) && (rem_q == 12'd0)) ||
	                       ((wst_q == W_PREP) && bad_c);
	assign res.bad_inset = (wst_q == W_PREP);

endmodule
`default_nettype wire

FILE: hdl/offscreen_edge_marker_path.sv
// Top level of the off-screen edge marker path: control sequencer, point buffer, output stage.
// Usage:
//   s_axis carries one target point per beat (tdata = target_x, target_y, both signed).
//   m_axis returns the marker polyline: one beat per point, tuser = status, tlast on the
//   final beat of a target. A failure (target visible, bad settings, path too short or
//   buffer overflow) returns a single beat with zero coordinates and tlast set.
//   cfg writes the five settings by index; it is always ready and is only to be used
//   while no target is in flight.
// Flow:
//   One target at a time; s_axis_tready is low while it is worked on. A path passes the
//   check, the shared squarer when the target is within the hide radius on both axes
//   (a visible target fails there), walker setup (prep and anchor), one walker step per
//   point (2 to 6 points), a drain of the buffer at one point per cycle while m_axis is
//   ready, and a return to idle.
// Reset: arst_n clears control, point count and the output stage, and loads the
//   default settings (144 x 168 screen, radius 0, inset 2, length 40).
// Stall: a stalled m_axis holds its beat; the buffer drain waits, and the next
//   target is accepted as soon as the last beat of the previous one is registered.
`default_nettype none
module offscreen_edge_marker_path #(
	parameter int MAX_POINTS = oemp_pkg::MAX_POINTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// stream in: [31:0] target_x, [63:32] target_y
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,
	// stream out: [9:0] coord_x, [19:10] coord_y, [23:20] zero
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata,
	// [1:0] status
	output logic [1:0]       m_axis_tuser,
	// last_point
	output logic             m_axis_tlast,
	// settings write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [11:0] cfg_data
);
	import oemp_pkg::*;

	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int IW = $clog2(MAX_POINTS);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_CHECK = 3'd1;
	localparam logic [2:0] S_DIST  = 3'd2;
	localparam logic [2:0] S_WALK  = 3'd3;
	localparam logic [2:0] S_FAIL  = 3'd4;
	localparam logic [2:0] S_EMIT  = 3'd5;

	// settings
	logic [9:0]  scr_w_q, scr_h_q, rad_q;
	logic [8:0]  inset_q;
	logic [11:0] len_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q <= RST_SCREEN_W;
			scr_h_q <= RST_SCREEN_H;
			rad_q   <= RST_HIDE_RAD;
			inset_q <= RST_INSET;
			len_q   <= RST_MARK_LEN;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SCREEN_W: scr_w_q <= cfg_data[9:0];
				REG_SCREEN_H: scr_h_q <= cfg_data[9:0];
				REG_HIDE_RAD: rad_q   <= cfg_data[9:0];
				REG_INSET:    inset_q <= cfg_data[8:0];
				REG_MARK_LEN: len_q   <= cfg_data;
				default:      scr_w_q <= scr_w_q;
			endcase
		end
	end

	logic [2:0]         state_q;
	logic signed [31:0] px_q, py_q;
	logic [1:0]         code_q;
	logic [CW-1:0]      total_q;
	logic               ovf_q;
	logic [19:0]        last_q;
	logic [IW-1:0]      rd_q;
	logic [19:0]        pbuf [MAX_POINTS];

	assign s_axis_tready = (state_q == S_IDLE);
	wire in_beat = s_axis_tvalid && s_axis_tready;

	// settings sanity and per-axis distance from the screen
	logic               cfg_bad;
	logic signed [32:0] pxe, pye, wm1, hm1, dxs, dys;
	logic               near;

	always_comb begin
		cfg_bad = (scr_w_q <= 10'd1) || (scr_h_q <= 10'd1) || (len_q == 12'd0);
		pxe = {px_q[31], px_q};
		pye = {py_q[31], py_q};
		wm1 = $signed({23'd0, scr_w_q}) - 33'sd1;
		hm1 = $signed({23'd0, scr_h_q}) - 33'sd1;
		if (pxe < 33'sd0)    dxs = 33'sd0 - pxe;
		else if (pxe > wm1)  dxs = pxe - wm1;
		else                 dxs = 33'sd0;
		if (pye < 33'sd0)    dys = 33'sd0 - pye;
		else if (pye > hm1)  dys = pye - hm1;
		else                 dys = 33'sd0;
		near = (dxs <= $signed({23'd0, rad_q})) && (dys <= $signed({23'd0, rad_q}));
	end

	dist_res_t dres;
	pt_t       wpt;
	walk_res_t wres;
	logic      dist_start, walk_start;

	assign dist_start = (state_q == S_CHECK) && !cfg_bad && near;
	assign walk_start = ((state_q == S_CHECK) && !cfg_bad && !near) ||
	                    ((state_q == S_DIST) && dres.done && !dres.visible);

	oemp_dist u_dist (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dist_start),
		.dx     (dxs[9:0]),
		.dy     (dys[9:0]),
		.rad    (rad_q),
		.res    (dres)
	);

	oemp_walk u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (walk_start),
		.px       (px_q),
		.py       (py_q),
		.scr_w    (scr_w_q),
		.scr_h    (scr_h_q),
		.inset    (inset_q),
		.mark_len (len_q),
		.pt       (wpt),
		.res      (wres)
	);

	// point capture with duplicate drop
	logic          pt_dup, pt_wr, ovf_set;
	logic [CW-1:0] tot_nx;

	always_comb begin
		pt_dup  = (total_q != '0) && (last_q == {wpt.y, wpt.x});
		pt_wr   = wpt.valid && !ovf_q && !pt_dup && (total_q < CW'(MAX_POINTS));
		ovf_set = wpt.valid && !ovf_q && !pt_dup && (total_q >= CW'(MAX_POINTS));
		tot_nx  = total_q + CW'(pt_wr);
	end

	always_ff @(posedge clk) begin
		if (pt_wr) begin
			pbuf[total_q[IW-1:0]] <= {wpt.y, wpt.x};
			last_q                <= {wpt.y, wpt.x};
		end
		if (in_beat) begin
			px_q <= s_axis_tdata[31:0];
			py_q <= s_axis_tdata[63:32];
		end
	end

	wire out_free = !m_axis_tvalid || m_axis_tready;
	wire emit_last = (CW'(rd_q) + CW'(1)) == total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			total_q <= '0;
			ovf_q   <= 1'b0;
			rd_q    <= '0;
			code_q  <= ST_POINT;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						total_q <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					priority if (cfg_bad) begin
						code_q  <= ST_BAD_CFG;
						state_q <= S_FAIL;
					end else if (near) begin
						state_q <= S_DIST;
					end else begin
						state_q <= S_WALK;
					end
				end
				S_DIST: begin
					if (dres.done) begin
						if (dres.visible) begin
							code_q  <= ST_VISIBLE;
							state_q <= S_FAIL;
						end else begin
							state_q <= S_WALK;
						end
					end
				end
				S_WALK: begin
					total_q <= tot_nx;
					if (ovf_set) ovf_q <= 1'b1;
					if (wres.done) begin
						priority if (wres.bad_inset) begin
							code_q  <= ST_BAD_CFG;
							state_q <= S_FAIL;
						end else if (ovf_q || ovf_set || (tot_nx < CW'(2))) begin
							code_q  <= ST_BAD_PATH;
							state_q <= S_FAIL;
						end else begin
							rd_q    <= '0;
							state_q <= S_EMIT;
						end
					end
				end
				S_FAIL: begin
					if (out_free) begin
						total_q <= '0;
						state_q <= S_IDLE;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						rd_q <= rd_q + IW'(1);
						if (emit_last) state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if ((state_q == S_FAIL || state_q == S_EMIT) && out_free) begin
			m_axis_tvalid <= 1'b1;
		end else if (m_axis_tready) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == S_FAIL) begin
				m_axis_tdata <= '0;
				m_axis_tuser <= code_q;
				m_axis_tlast <= 1'b1;
			end else if (state_q == S_EMIT) begin
				m_axis_tdata <= {4'd0, pbuf[rd_q]};
				m_axis_tuser <= ST_POINT;
				m_axis_tlast <= emit_last;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CW'(MAX_POINTS))
		else $error("point count beyond buffer depth");

	a_fail_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser != ST_POINT)) |-> (m_axis_tdata == '0 && m_axis_tlast))
		else $error("status beat with coordinates or without tlast");

	a_emit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (total_q >= CW'(2) && !ovf_q))
		else $error("draining a path that should have failed");

	a_walk_window: assert property (@(posedge clk) disable iff (!arst_n)
		wpt.valid |-> (state_q == S_WALK))
		else $error("walker point outside the walk phase");
`endif

endmodule
`default_nettype wire
